// File: rtl/core/dps_pkg.sv
// Shared constants, types and the PACE prefix table for the DER scanner.
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;

  localparam int DEFAULT_DEPTH = 256;
  localparam int OFFSET_W      = 9;

  // DER tags and fixed bytes
  localparam logic [7:0] TAG_SET    = 8'h31;
  localparam logic [7:0] TAG_SEQ    = 8'h30;
  localparam logic [7:0] TAG_OID    = 8'h06;
  localparam logic [7:0] TAG_INT    = 8'h02;
  localparam logic [7:0] INT_LEN    = 8'h01;
  localparam logic [7:0] OID_LEN    = 8'h0A;
  localparam logic [7:0] ZERO_LEN   = 8'h00;
  localparam int         PREFIX_LEN = 8;
  localparam int         OID_SKIP   = 2 + 10;  // tag, length, ten content bytes
  localparam int         INT_SKIP   = 3;       // 02 01 vv

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] error_offset;
    logic                pace_found;
    logic [15:0]         oid_tail;
    logic [7:0]          version;
    logic [7:0]          param_id;
  } dps_result_t;

  function automatic logic [7:0] pace_prefix(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'h04;
      3'd1:    v = 8'h00;
      3'd2:    v = 8'h7F;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h07;
      3'd5:    v = 8'h02;
      3'd6:    v = 8'h02;
      default: v = 8'h04;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dps_if.sv
// Valid/ready channel interfaces for the byte feed and the scan result.
`timescale 1ns / 1ps
`default_nettype none
interface dps_feed_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dps_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [8:0]  error_offset;
  logic        pace_found;
  logic [15:0] oid_tail;
  logic [7:0]  version;
  logic [7:0]  param_id;

  modport source (output valid, output status, output error_offset, output pace_found,
                  output oid_tail, output version, output param_id, input ready);
  modport sink   (input valid, input status, input error_offset, input pace_found,
                  input oid_tail, input version, input param_id, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dps_buffer.sv
// File buffer: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dps_buffer
  import dps_pkg::*;
#(
  parameter  int DEPTH = DEFAULT_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dps_walker.sv
// Load counter and TLV walk sequencer that reads the file buffer byte by byte.
`timescale 1ns / 1ps
`default_nettype none
module dps_walker
  import dps_pkg::*;
#(
  parameter  int DEPTH = DEFAULT_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [7:0]    in_data,
  input  wire logic          in_last,
  output      logic          mem_wr_en,
  output      logic [AW-1:0] mem_wr_addr,
  output      logic [7:0]    mem_wr_data,
  output      logic          mem_rd_en,
  output      logic [AW-1:0] mem_rd_addr,
  input  wire logic [7:0]    mem_rd_data,
  output      logic          res_valid,
  input  wire logic          res_ready,
  output      dps_result_t   res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH + 300);  // room for index plus longest skip

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [3:0] ST_TAG = 4'd0;
  localparam logic [3:0] ST_LEN = 4'd1;
  localparam logic [3:0] ST_PFX = 4'd2;
  localparam logic [3:0] ST_TH  = 4'd3;
  localparam logic [3:0] ST_TL  = 4'd4;
  localparam logic [3:0] ST_V0  = 4'd5;
  localparam logic [3:0] ST_V1  = 4'd6;
  localparam logic [3:0] ST_V2  = 4'd7;
  localparam logic [3:0] ST_P0  = 4'd8;
  localparam logic [3:0] ST_P1  = 4'd9;
  localparam logic [3:0] ST_P2  = 4'd10;

  logic [2:0]          state;
  logic [3:0]          step;
  logic [2:0]          k;
  logic [CW-1:0]       count;
  logic [IW-1:0]       idx;    // start of the element being parsed
  logic [IW-1:0]       ptr;    // byte being fetched
  logic                in_range;
  logic [7:0]          tag;
  logic [7:0]          tail_hi;
  logic                found;
  logic [15:0]         tail;
  logic [7:0]          ver;
  logic [7:0]          par;
  logic                err;
  logic [OFFSET_W-1:0] err_off;

  logic          accept;
  logic [7:0]    b;
  logic [IW-1:0] count_ext;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign count_ext   = IW'(count);
  assign b           = in_range ? mem_rd_data : 8'h00;

  assign mem_wr_en   = accept && (count < CW'(DEPTH));
  assign mem_wr_addr = count[AW-1:0];
  assign mem_wr_data = in_data;
  assign mem_rd_en   = (state == S_RD) && (ptr < count_ext);
  assign mem_rd_addr = ptr[AW-1:0];

  assign res_valid         = (state == S_DONE);
  assign res.status        = err;
  assign res.error_offset  = err_off;
  assign res.pace_found    = found;
  assign res.oid_tail      = tail;
  assign res.version       = ver;
  assign res.param_id      = par;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count < CW'(DEPTH)) begin
              count <= count + CW'(1);
            end
            if (in_last) begin
              found   <= 1'b0;
              tail    <= '0;
              ver     <= '0;
              par     <= '0;
              err     <= 1'b0;
              err_off <= '0;
              idx     <= '0;
              state   <= S_CHK;
            end
          end
        end
        S_CHK: begin
          // continue while at least tag and length lie inside the file
          if ((idx + IW'(2)) <= count_ext) begin
            ptr   <= idx;
            step  <= ST_TAG;
            state <= S_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_RD: begin
          in_range <= (ptr < count_ext);
          state    <= S_EX;
        end
        S_EX: begin
          case (step)
            ST_TAG: begin
              tag   <= b;
              ptr   <= ptr + IW'(1);
              step  <= ST_LEN;
              state <= S_RD;
            end
            ST_LEN: begin
              if (tag == TAG_SET || tag == TAG_SEQ) begin
                // enter the constructed element, skipping long-form length bytes
                idx   <= idx + IW'(2) + (b[7] ? IW'(b[6:0]) : IW'(0));
                state <= S_CHK;
              end else if (tag == TAG_OID && b == OID_LEN) begin
                k     <= '0;
                ptr   <= ptr + IW'(1);
                step  <= ST_PFX;
                state <= S_RD;
              end else if (tag != TAG_OID && b == ZERO_LEN) begin
                err     <= 1'b1;
                err_off <= idx[OFFSET_W-1:0];
                state   <= S_DONE;
              end else begin
                idx   <= idx + IW'(2) + IW'(b);
                state <= S_CHK;
              end
            end
            ST_PFX: begin
              if (b != pace_prefix(k)) begin
                idx   <= idx + IW'(OID_SKIP);
                state <= S_CHK;
              end else begin
                ptr   <= ptr + IW'(1);
                state <= S_RD;
                if (k == 3'(PREFIX_LEN - 1)) begin
                  step <= ST_TH;
                end else begin
                  k <= k + 3'd1;
                end
              end
            end
            ST_TH: begin
              tail_hi <= b;
              ptr     <= ptr + IW'(1);
              step    <= ST_TL;
              state   <= S_RD;
            end
            ST_TL: begin
              found <= 1'b1;
              tail  <= {tail_hi, b};
              ver   <= '0;
              par   <= '0;
              idx   <= idx + IW'(OID_SKIP);
              ptr   <= ptr + IW'(1);
              step  <= ST_V0;
              state <= S_RD;
            end
            ST_V0, ST_V1: begin
              // version INTEGER is mandatory after a PACE OID
              if (b != ((step == ST_V0) ? TAG_INT : INT_LEN)) begin
                err     <= 1'b1;
                err_off <= idx[OFFSET_W-1:0];
                state   <= S_DONE;
              end else begin
                ptr   <= ptr + IW'(1);
                step  <= (step == ST_V0) ? ST_V1 : ST_V2;
                state <= S_RD;
              end
            end
            ST_V2: begin
              ver   <= b;
              idx   <= idx + IW'(INT_SKIP);
              ptr   <= ptr + IW'(1);
              step  <= ST_P0;
              state <= S_RD;
            end
            ST_P0, ST_P1: begin
              if (b != ((step == ST_P0) ? TAG_INT : INT_LEN)) begin
                state <= S_CHK;
              end else begin
                ptr   <= ptr + IW'(1);
                step  <= (step == ST_P0) ? ST_P1 : ST_P2;
                state <= S_RD;
              end
            end
            ST_P2: begin
              par   <= b;
              idx   <= idx + IW'(INT_SKIP);
              state <= S_CHK;
            end
            default: begin
              state <= S_CHK;
            end
          endcase
        end
        S_DONE: begin
          if (res_ready) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/der_pace_info_scanner_top.sv
// Top level of the DER PACE security-info scanner: buffer, walker, result register.
//
// Bytes of a DER file stream in on the feed channel, one beat per cycle while
// the walker is idle, and are stored in a BUFFER_DEPTH-entry buffer; bytes past
// the depth are dropped. The beat marked last starts a walk of the buffer that
// accepts no feed beats until its result has been handed to the result register.
// Each byte fetched takes a read state and an examine state (the buffer's read
// port is registered), each element a bound check, and the result is handed over
// from a done state. SET and SEQUENCE headers and skipped elements read only tag
// and length (a length-ten OID also reads its prefix up to the first mismatch),
// and a PACE OID with its INTEGERs reads up to 18 bytes. The result register lets
// a new file load while the previous result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module der_pace_info_scanner_top
  import dps_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input wire logic     clk,
  input wire logic     rst,
  dps_feed_if.sink     feed,
  dps_result_if.source result
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          res_valid;
  logic          res_ready;
  dps_result_t   res;
  dps_result_t   out_q;
  logic          out_valid;

  dps_buffer #(.DEPTH(BUFFER_DEPTH)) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dps_walker #(.DEPTH(BUFFER_DEPTH)) u_walker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (feed.valid),
    .in_ready    (feed.ready),
    .in_data     (feed.data_byte),
    .in_last     (feed.last_byte),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_q.status;
  assign result.error_offset = out_q.error_offset;
  assign result.pace_found   = out_q.pace_found;
  assign result.oid_tail     = out_q.oid_tail;
  assign result.version      = out_q.version;
  assign result.param_id     = out_q.param_id;

endmodule
`default_nettype wire

// File: rtl/core/dps_checker.sv
// Port-level assertions for the scanner top, bound to every instance.
`timescale 1ns / 1ps
`default_nettype none
module dps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        status,
  input wire logic [8:0]  error_offset,
  input wire logic        pace_found,
  input wire logic [15:0] oid_tail,
  input wire logic [7:0]  version,
  input wire logic [7:0]  param_id
);

  // a pending result beat is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> error_offset == 9'd0)
    else $error("nonzero error offset on success");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pace_found |-> oid_tail == 16'd0 && version == 8'd0 && param_id == 8'd0)
    else $error("PACE fields set without a PACE OID");

endmodule

bind der_pace_info_scanner_top dps_checker u_dps_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .status       (result.status),
  .error_offset (result.error_offset),
  .pace_found   (result.pace_found),
  .oid_tail     (result.oid_tail),
  .version      (result.version),
  .param_id     (result.param_id)
);
`default_nettype wire

// File: tb/der_pace_info_scanner_checker.sv
// Checker for the DER PACE scanner: predicts each scan result from the byte feed and compares.
`timescale 1ns / 1ps
module der_pace_info_scanner_checker
  import dps_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  dps_feed_if    feed,
  dps_result_if  result,
  output int     fail_count,
  output int     pending
);

  localparam logic [7:0] PACE_HEAD [PREFIX_LEN] =
    '{8'h04, 8'h00, 8'h7F, 8'h00, 8'h07, 8'h02, 8'h02, 8'h04};

  logic [7:0]  file_mem [BUFFER_DEPTH];
  int unsigned file_len;
  dps_result_t scan_results_q [$];
  dps_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    file_len   = 0;
  end

  // bytes at or past the stored length read as zero
  function automatic logic [7:0] peek(input int unsigned i);
    if (i >= file_len || i >= BUFFER_DEPTH) return 8'h00;
    return file_mem[i];
  endfunction

  function automatic logic int1_at(input int unsigned i);
    return peek(i) == TAG_INT && peek(i + 1) == INT_LEN;
  endfunction

  function automatic dps_result_t walk_der_file();
    dps_result_t r;
    int unsigned idx;
    int unsigned at;
    logic [7:0]  tag;
    logic [7:0]  ln;
    logic        hit;
    logic        bad;
    r   = '0;
    idx = 0;
    bad = 1'b0;
    if (file_len >= 2) begin
      while (!bad && idx <= file_len - 2) begin
        at  = idx;
        tag = peek(at);
        ln  = peek(at + 1);
        if (tag == TAG_SET || tag == TAG_SEQ) begin
          idx = at + 2;
          if (ln[7]) idx += ln[6:0];
        end else if (tag == TAG_OID) begin
          hit = (ln == OID_LEN);
          for (int k = 0; k < PREFIX_LEN; k++)
            if (peek(at + 2 + k) != PACE_HEAD[k]) hit = 1'b0;
          if (hit) begin
            // a later PACE OID replaces everything recorded before
            r.pace_found = 1'b1;
            r.oid_tail   = {peek(at + 10), peek(at + 11)};
            r.version    = 8'h00;
            r.param_id   = 8'h00;
            idx = at + OID_SKIP;
            if (!int1_at(idx)) begin
              bad = 1'b1;
            end else begin
              r.version = peek(idx + 2);
              idx += INT_SKIP;
              if (int1_at(idx)) begin
                r.param_id = peek(idx + 2);
                idx += INT_SKIP;
              end
            end
          end else begin
            idx = at + 2 + ln;
          end
        end else if (ln == ZERO_LEN) begin
          bad = 1'b1;
        end else begin
          idx = at + 2 + ln;
        end
      end
    end
    r.status       = bad;
    r.error_offset = bad ? idx[8:0] : '0;
    return r;
  endfunction

  task automatic report(input string what);
    $display("%0t ns: scan result mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      file_len = 0;
      scan_results_q.delete();
    end else begin
      // result side first so a result beat is never matched to a file closing this edge
      if (result.valid && result.ready) begin
        if (scan_results_q.size() == 0) begin
          report("result beat with no scan pending");
        end else begin
          want = scan_results_q.pop_front();
          check_field("status", result.status, want.status);
          check_field("error_offset", result.error_offset, want.error_offset);
          check_field("pace_found", result.pace_found, want.pace_found);
          check_field("oid_tail", result.oid_tail, want.oid_tail);
          check_field("version", result.version, want.version);
          check_field("param_id", result.param_id, want.param_id);
        end
      end
      if (feed.valid && feed.ready) begin
        if (file_len < BUFFER_DEPTH) begin
          file_mem[file_len] = feed.data_byte;
          file_len++;
        end
        if (feed.last_byte) begin
          scan_results_q.push_back(walk_der_file());
          file_len = 0;
        end
      end
    end
    pending = scan_results_q.size();
  end

endmodule

// File: tb/der_pace_info_scanner_top_tb.sv
// Testbench top for the DER PACE scanner: clock, reset, byte-file stimulus and verdict.
`timescale 1ns / 1ps
module der_pace_info_scanner_top_tb;
  import dps_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int RANDOM_BYTES = 1100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 1200;
  localparam int LIMIT_NS     = 2_000_000;

  localparam logic [7:0] TAG_OCTETS    = 8'h04;
  localparam logic [7:0] TAG_NULL      = 8'h05;
  localparam logic [7:0] TAG_UTF8      = 8'h0C;
  localparam logic [7:0] TAG_PRINTABLE = 8'h13;
  localparam logic [7:0] LONG_FORM     = 8'h80;

  logic clk;
  logic rst;
  logic idle_on = 1'b1;
  logic hold_go = 1'b0;
  int   fail_count;
  int   pending;
  int   bytes_sent;
  logic [7:0] file_bytes [$];

  dps_feed_if   feed_ch ();
  dps_result_if result_ch ();

  der_pace_info_scanner_top #(.BUFFER_DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .result (result_ch)
  );

  der_pace_info_scanner_checker #(.BUFFER_DEPTH(DEPTH)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #LIMIT_NS;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !(idle_on && $urandom_range(0, 99) < 25);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      feed_ch.valid <= 1'b0;
      @(negedge clk);
    end
    feed_ch.valid     <= 1'b1;
    feed_ch.data_byte <= b;
    feed_ch.last_byte <= last;
    @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_beat(file_bytes[i], i == file_bytes.size() - 1);
    bytes_sent += file_bytes.size();
    file_bytes.delete();
  endtask

  // variant 0: no version INTEGER, 1: version only, 2: version and parameter ID
  task automatic add_pace_oid(input int variant);
    file_bytes.push_back(TAG_OID);
    file_bytes.push_back(OID_LEN);
    for (int k = 0; k < PREFIX_LEN; k++) file_bytes.push_back(pace_prefix(3'(k)));
    file_bytes.push_back(rand_byte());
    file_bytes.push_back(rand_byte());
    repeat ((variant > 2) ? 2 : variant) begin
      file_bytes.push_back(TAG_INT);
      file_bytes.push_back(INT_LEN);
      file_bytes.push_back(rand_byte());
    end
  endtask

  task automatic add_header();
    int n;
    file_bytes.push_back($urandom_range(0, 1) ? TAG_SEQ : TAG_SET);
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 2);
      file_bytes.push_back(LONG_FORM | 8'(n));
      // a huge count just runs the index off the end
      repeat ((n > 2) ? 0 : n) file_bytes.push_back(rand_byte());
    end else begin
      file_bytes.push_back(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic add_filler();
    int len;
    case ($urandom_range(0, 4))
      0:       file_bytes.push_back(TAG_OCTETS);
      1:       file_bytes.push_back(TAG_NULL);
      2:       file_bytes.push_back(TAG_UTF8);
      3:       file_bytes.push_back(TAG_PRINTABLE);
      default: file_bytes.push_back(rand_byte());
    endcase
    len = $urandom_range(1, 6);
    file_bytes.push_back(8'(len));
    repeat (len) file_bytes.push_back(rand_byte());
  endtask

  // OID that is not PACE: one prefix byte off, or a plain short OID
  task automatic add_other_oid();
    int j;
    int len;
    file_bytes.push_back(TAG_OID);
    if ($urandom_range(0, 1)) begin
      j = $urandom_range(0, PREFIX_LEN - 1);
      file_bytes.push_back(OID_LEN);
      for (int k = 0; k < PREFIX_LEN; k++)
        file_bytes.push_back(pace_prefix(3'(k)) ^ ((k == j) ? 8'($urandom_range(1, 255)) : 8'h00));
      file_bytes.push_back(rand_byte());
      file_bytes.push_back(rand_byte());
    end else begin
      len = $urandom_range(1, 9);
      file_bytes.push_back(8'(len));
      repeat (len) file_bytes.push_back(rand_byte());
    end
  endtask

  function automatic int pick_variant();
    int r;
    r = $urandom_range(0, 19);
    return (r < 3) ? 0 : (r < 10) ? 1 : 2;
  endfunction

  task automatic build_random_file();
    int kind;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 24)) file_bytes.push_back(rand_byte());
    end else if (kind < 12) begin
      repeat ($urandom_range(1, 2)) file_bytes.push_back(rand_byte());
    end else begin
      add_header();
      if ($urandom_range(0, 1)) add_header();
      repeat ($urandom_range(0, 2)) add_filler();
      pick = $urandom_range(0, 9);
      if (pick < 7) add_pace_oid(pick_variant());
      else if (pick < 9) add_other_oid();
      if ($urandom_range(0, 9) == 0) add_pace_oid(pick_variant());
      if ($urandom_range(0, 1)) add_filler();
      if (kind < 22) begin
        file_bytes.push_back(TAG_OCTETS);
        file_bytes.push_back(ZERO_LEN);
      end else if (kind < 32) begin
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = rand_byte();
      end else if (kind < 38) begin
        repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
      end
    end
  endtask

  initial begin : stimulus
    int file_no;
    feed_ch.valid     = 1'b0;
    feed_ch.data_byte = 8'h00;
    feed_ch.last_byte = 1'b0;
    bytes_sent        = 0;
    file_no           = 0;
    wait (!rst);
    @(negedge clk);

    // single-byte file: walk skipped
    file_bytes = '{8'hFF};
    send_file();
    // zero length right at the start
    file_bytes = '{8'h00, ZERO_LEN};
    send_file();
    // long-form SEQUENCE around a PACE OID with a version
    file_bytes = '{TAG_SEQ, LONG_FORM | 8'h01, 8'h0F};
    add_pace_oid(1);
    send_file();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      idle_on = !(file_no >= 10 && file_no < 18);
      if (file_no == 6) hold_go = 1'b1;
      if (file_no == 20) begin
        // drop the last beat so it is not taken again while waiting
        feed_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (file_no == 3) begin
        // overlong file: everything past the buffer depth is dropped
        add_header();
        add_pace_oid(2);
        while (file_bytes.size() < DEPTH + 6) add_filler();
      end else begin
        build_random_file();
      end
      send_file();
      file_no++;
    end
    feed_ch.valid <= 1'b0;
    idle_on = 1'b1;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: der_pace_info_scanner_top.f
rtl/core/dps_pkg.sv
rtl/core/dps_if.sv
rtl/core/dps_buffer.sv
rtl/core/dps_walker.sv
rtl/core/der_pace_info_scanner_top.sv
rtl/core/dps_checker.sv
tb/der_pace_info_scanner_checker.sv
tb/der_pace_info_scanner_top_tb.sv
